// ===== rtl/lsg_pkg.sv =====
// Shared types and constants for the line segment geometry unit.
`default_nettype none
package lsg_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        FUNC_GRAD    = 2'd0,
        FUNC_CLOSEST = 2'd1,
        FUNC_ISECT   = 2'd2,
        FUNC_LAMBDA  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    // per-item control that rides along with the datapath
    typedef struct packed {
        logic  valid;
        t_func func;
        logic  degen;   // zero divisor: vertical, zero length or parallel
        logic  t_zero;  // closest point: projection clamps to 0
        logic  t_one;   // closest point: projection clamps to 1.0
        logic  q_neg;   // sign of the quotient
    } t_ctrl;

endpackage
`default_nettype wire

// ===== rtl/line_segment_geometry_unit_top.sv =====
// Top level of the 2D line unit: gradient, closest point, intersection point and lambda.
// Every function takes the same path: front end, divider chain, back end (Q16.16 by default).
// Throughput: one transaction per cycle while the pipeline advances, which it does whenever
// the output register is empty or being taken.
// Reset (synchronous, active low) clears all valid bits; the datapath is not reset.
`default_nettype none
module line_segment_geometry_unit_top #(
    parameter int COORD_WIDTH = lsg_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = lsg_pkg::FRAC_BITS_DEF,
    localparam int IN_DW  = ((8*COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((3*COORD_WIDTH + 7) / 8) * 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    // start_x, start_y, dir_x, dir_y, other_x, other_y, other_dir_x, other_dir_y
    input  wire [IN_DW-1:0]   s_axis_tdata,
    // func
    input  wire [1:0]         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    // result_x, result_y, scalar
    output logic [OUT_DW-1:0] m_axis_tdata,
    // status
    output logic [1:0]        m_axis_tuser
);
    import lsg_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int QW = W + FRAC_BITS + 2;

    logic                       w_en;
    t_ctrl                      w_fe_ctrl, w_div_ctrl;
    logic [W-1:0]               w_fe_sx, w_fe_sy, w_fe_vx, w_fe_vy;
    logic [W-1:0]               w_dv_sx, w_dv_sy, w_dv_vx, w_dv_vy;
    logic [2*W+FRAC_BITS:0]     w_fe_num;
    logic [2*W-1:0]             w_fe_den;
    logic                       w_fe_big, w_div_big;
    logic [QW-1:0]              w_div_q;
    logic                       w_out_valid;
    logic [W-1:0]               w_rx, w_ry, w_sc;
    t_status                    w_status;

    // whole pipeline moves together; stalls only when the output is held
    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    lsg_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (s_axis_tvalid),
        .i_func        (t_func'(s_axis_tuser)),
        .i_start_x     (s_axis_tdata[0*W +: W]),
        .i_start_y     (s_axis_tdata[1*W +: W]),
        .i_dir_x       (s_axis_tdata[2*W +: W]),
        .i_dir_y       (s_axis_tdata[3*W +: W]),
        .i_other_x     (s_axis_tdata[4*W +: W]),
        .i_other_y     (s_axis_tdata[5*W +: W]),
        .i_other_dir_x (s_axis_tdata[6*W +: W]),
        .i_other_dir_y (s_axis_tdata[7*W +: W]),
        .o_ctrl        (w_fe_ctrl),
        .o_start_x     (w_fe_sx),
        .o_start_y     (w_fe_sy),
        .o_dir_x       (w_fe_vx),
        .o_dir_y       (w_fe_vy),
        .o_num         (w_fe_num),
        .o_den         (w_fe_den),
        .o_big         (w_fe_big)
    );

    lsg_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_ctrl    (w_fe_ctrl),
        .i_start_x (w_fe_sx),
        .i_start_y (w_fe_sy),
        .i_dir_x   (w_fe_vx),
        .i_dir_y   (w_fe_vy),
        .i_num     (w_fe_num),
        .i_den     (w_fe_den),
        .i_big     (w_fe_big),
        .o_ctrl    (w_div_ctrl),
        .o_start_x (w_dv_sx),
        .o_start_y (w_dv_sy),
        .o_dir_x   (w_dv_vx),
        .o_dir_y   (w_dv_vy),
        .o_quo     (w_div_q),
        .o_big     (w_div_big)
    );

    lsg_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_ctrl     (w_div_ctrl),
        .i_start_x  (w_dv_sx),
        .i_start_y  (w_dv_sy),
        .i_dir_x    (w_dv_vx),
        .i_dir_y    (w_dv_vy),
        .i_quo      (w_div_q),
        .i_big      (w_div_big),
        .o_valid    (w_out_valid),
        .o_result_x (w_rx),
        .o_result_y (w_ry),
        .o_scalar   (w_sc),
        .o_status   (w_status)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tuser  = w_status;

    always_comb begin
        m_axis_tdata            = '0;
        m_axis_tdata[0*W +: W]  = w_rx;
        m_axis_tdata[1*W +: W]  = w_ry;
        m_axis_tdata[2*W +: W]  = w_sc;
    end

    // projection strictly inside the segment must give t below 1.0
    a_closest_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctrl.valid && (w_div_ctrl.func == FUNC_CLOSEST) && !w_div_ctrl.degen &&
        !w_div_ctrl.t_zero && !w_div_ctrl.t_one
        |-> !w_div_big && (w_div_q[QW-1:FRAC_BITS] == '0))
        else $error("closest point projection out of range");

    // gradient quotient always fits the divider's quotient field
    a_grad_no_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctrl.valid && (w_div_ctrl.func == FUNC_GRAD) && !w_div_ctrl.degen
        |-> !w_div_big)
        else $error("gradient quotient overflow flagged");

    // a held output transaction keeps the whole pipeline frozen
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(w_div_ctrl) && $stable(w_div_q))
        else $error("pipeline moved during output stall");

endmodule
`default_nettype wire

// ===== rtl/lsg_front.sv =====
// Front end: differences, cross and dot products, divider operand setup.
`default_nettype none
module lsg_front #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_valid,
    input  wire lsg_pkg::t_func            i_func,
    input  wire [COORD_WIDTH-1:0]          i_start_x,
    input  wire [COORD_WIDTH-1:0]          i_start_y,
    input  wire [COORD_WIDTH-1:0]          i_dir_x,
    input  wire [COORD_WIDTH-1:0]          i_dir_y,
    input  wire [COORD_WIDTH-1:0]          i_other_x,
    input  wire [COORD_WIDTH-1:0]          i_other_y,
    input  wire [COORD_WIDTH-1:0]          i_other_dir_x,
    input  wire [COORD_WIDTH-1:0]          i_other_dir_y,
    output lsg_pkg::t_ctrl                 o_ctrl,
    output logic [COORD_WIDTH-1:0]         o_start_x,
    output logic [COORD_WIDTH-1:0]         o_start_y,
    output logic [COORD_WIDTH-1:0]         o_dir_x,
    output logic [COORD_WIDTH-1:0]         o_dir_y,
    output logic [2*COORD_WIDTH+FRAC_BITS:0] o_num,
    output logic [2*COORD_WIDTH-1:0]       o_den,
    output logic                           o_big
);
    import lsg_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2*W + F + 1;
    localparam int DW = 2*W;
    localparam int QW = W + F + 2;
    localparam int PW = 2*W + 2;

    // stage 1: register inputs and start offsets
    logic                r1_valid;
    t_func               r1_func;
    logic [W-1:0]        r1_sx, r1_sy, r1_vx, r1_vy, r1_wx, r1_wy;
    logic signed [W:0]   r1_dx, r1_dy;
    logic signed [W:0]   n1_dx, n1_dy;

    assign n1_dx = {i_other_x[W-1], i_other_x} - {i_start_x[W-1], i_start_x};
    assign n1_dy = {i_other_y[W-1], i_other_y} - {i_start_y[W-1], i_start_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_func <= i_func;
            r1_sx   <= i_start_x;
            r1_sy   <= i_start_y;
            r1_vx   <= i_dir_x;
            r1_vy   <= i_dir_y;
            r1_wx   <= i_other_dir_x;
            r1_wy   <= i_other_dir_y;
            r1_dx   <= n1_dx;
            r1_dy   <= n1_dy;
        end
    end

    // stage 2: four products
    logic signed [W:0]    n2_a1, n2_a2, n2_b1, n2_b2, n2_c1, n2_c2, n2_d1, n2_d2;
    logic signed [PW-1:0] r2_pa, r2_pb, r2_pc, r2_pd;
    logic                 r2_valid;
    t_func                r2_func;
    logic [W-1:0]         r2_sx, r2_sy, r2_vx, r2_vy;

    always_comb begin
        if (r1_func == FUNC_CLOSEST) begin
            n2_a1 = {r1_vx[W-1], r1_vx};  n2_a2 = {r1_vx[W-1], r1_vx};
            n2_b1 = {r1_vy[W-1], r1_vy};  n2_b2 = {r1_vy[W-1], r1_vy};
            n2_c1 = r1_dx;                n2_c2 = {r1_vx[W-1], r1_vx};
            n2_d1 = r1_dy;                n2_d2 = {r1_vy[W-1], r1_vy};
        end else begin
            n2_a1 = {r1_wx[W-1], r1_wx};  n2_a2 = {r1_vy[W-1], r1_vy};
            n2_b1 = {r1_vx[W-1], r1_vx};  n2_b2 = {r1_wy[W-1], r1_wy};
            n2_c1 = {r1_wx[W-1], r1_wx};  n2_c2 = r1_dy;
            n2_d1 = r1_dx;                n2_d2 = {r1_wy[W-1], r1_wy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pa   <= n2_a1 * n2_a2;
            r2_pb   <= n2_b1 * n2_b2;
            r2_pc   <= n2_c1 * n2_c2;
            r2_pd   <= n2_d1 * n2_d2;
            r2_func <= r1_func;
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;
        end
    end

    // stage 3: numerator and divisor (dot products or determinants)
    logic signed [PW-1:0] r3_num, r3_den;
    logic                 r3_valid;
    t_func                r3_func;
    logic [W-1:0]         r3_sx, r3_sy, r3_vx, r3_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r2_func == FUNC_CLOSEST) begin
                r3_den <= r2_pa + r2_pb;
                r3_num <= r2_pc + r2_pd;
            end else begin
                r3_den <= r2_pa - r2_pb;
                r3_num <= r2_pc - r2_pd;
            end
            r3_func <= r2_func;
            r3_sx   <= r2_sx;
            r3_sy   <= r2_sy;
            r3_vx   <= r2_vx;
            r3_vy   <= r2_vy;
        end
    end

    // stage 4: magnitudes, special cases, divider operands
    logic [PW-1:0] n4_num_mag, n4_den_mag;
    logic [W-1:0]  n4_ax, n4_ay;
    logic [NW-1:0] n4_n;
    logic [DW-1:0] n4_d;
    t_ctrl         n4_ctrl;
    logic          n4_num_le0;
    t_ctrl         r4_ctrl;
    logic [NW-1:0] r4_n;
    logic [DW-1:0] r4_d;
    logic [W-1:0]  r4_sx, r4_sy, r4_vx, r4_vy;

    always_comb begin
        n4_num_mag = r3_num[PW-1] ? PW'(-r3_num) : PW'(r3_num);
        n4_den_mag = r3_den[PW-1] ? PW'(-r3_den) : PW'(r3_den);
        n4_ax      = r3_vx[W-1] ? W'(-r3_vx) : r3_vx;
        n4_ay      = r3_vy[W-1] ? W'(-r3_vy) : r3_vy;
        n4_num_le0 = r3_num[PW-1] || (r3_num == '0);
        n4_ctrl        = '0;
        n4_ctrl.valid  = r3_valid;
        n4_ctrl.func   = r3_func;
        n4_n = {n4_num_mag[2*W:0], {F{1'b0}}};
        n4_d = n4_den_mag[DW-1:0];
        case (r3_func)
            FUNC_GRAD: begin
                n4_n = {{(NW-F-W){1'b0}}, n4_ay, {F{1'b0}}};
                n4_d = {{W{1'b0}}, n4_ax};
                n4_ctrl.degen = (r3_vx == '0);
                n4_ctrl.q_neg = r3_vx[W-1] ^ r3_vy[W-1];
            end
            FUNC_CLOSEST: begin
                n4_ctrl.degen  = (r3_den == '0);
                n4_ctrl.t_zero = n4_num_le0;
                n4_ctrl.t_one  = !n4_num_le0 &&
                                 (n4_num_mag[2*W:0] >= {1'b0, n4_den_mag[DW-1:0]});
            end
            default: begin
                n4_ctrl.degen = (r3_den == '0);
                n4_ctrl.q_neg = r3_num[PW-1] ^ r3_den[PW-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctrl <= '0;
        end else if (i_en) begin
            r4_ctrl <= n4_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_n  <= n4_n;
            r4_d  <= n4_d;
            r4_sx <= r3_sx;
            r4_sy <= r3_sy;
            r4_vx <= r3_vx;
            r4_vy <= r3_vy;
        end
    end

    // stage 5: quotient range check, N >= D * 2^QW
    t_ctrl r5_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctrl <= '0;
        end else if (i_en) begin
            r5_ctrl <= r4_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_big     <= {{(DW-(NW-QW)){1'b0}}, r4_n[NW-1:QW]} >= r4_d;
            o_num     <= r4_n;
            o_den     <= r4_d;
            o_start_x <= r4_sx;
            o_start_y <= r4_sy;
            o_dir_x   <= r4_vx;
            o_dir_y   <= r4_vy;
        end
    end

    assign o_ctrl = r5_ctrl;

endmodule
`default_nettype wire

// ===== rtl/lsg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module lsg_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire lsg_pkg::t_ctrl              i_ctrl,
    input  wire [COORD_WIDTH-1:0]            i_start_x,
    input  wire [COORD_WIDTH-1:0]            i_start_y,
    input  wire [COORD_WIDTH-1:0]            i_dir_x,
    input  wire [COORD_WIDTH-1:0]            i_dir_y,
    input  wire [2*COORD_WIDTH+FRAC_BITS:0]  i_num,
    input  wire [2*COORD_WIDTH-1:0]          i_den,
    input  wire                              i_big,
    output lsg_pkg::t_ctrl                   o_ctrl,
    output logic [COORD_WIDTH-1:0]           o_start_x,
    output logic [COORD_WIDTH-1:0]           o_start_y,
    output logic [COORD_WIDTH-1:0]           o_dir_x,
    output logic [COORD_WIDTH-1:0]           o_dir_y,
    output logic [COORD_WIDTH+FRAC_BITS+1:0] o_quo,
    output logic                             o_big
);
    import lsg_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2*W + F + 1;
    localparam int DW = 2*W;
    localparam int QW = W + F + 2;
    localparam int CW = 4*W;

    t_ctrl          r_ctrl [QW];
    logic [CW-1:0]  r_crd  [QW];
    logic [DW-1:0]  r_rem  [QW];
    logic [DW-1:0]  r_den  [QW];
    logic [QW-1:0]  r_lo   [QW];
    logic [QW-1:0]  r_quo  [QW];
    logic           r_big  [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            t_ctrl         w_ctrl;
            logic [CW-1:0] w_crd;
            logic [DW-1:0] w_rem, w_den;
            logic [QW-1:0] w_lo, w_quo;
            logic          w_big, w_ge;
            logic [DW:0]   w_trial, w_diff;

            if (k == 0) begin : g_first
                assign w_ctrl = i_ctrl;
                assign w_crd  = {i_dir_y, i_dir_x, i_start_y, i_start_x};
                // remainder starts as the bits above the quotient field
                assign w_rem  = {{(DW-(NW-QW)){1'b0}}, i_num[NW-1:QW]};
                assign w_den  = i_den;
                assign w_lo   = i_num[QW-1:0];
                assign w_quo  = '0;
                assign w_big  = i_big;
            end else begin : g_next
                assign w_ctrl = r_ctrl[k-1];
                assign w_crd  = r_crd[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_den  = r_den[k-1];
                assign w_lo   = r_lo[k-1];
                assign w_quo  = r_quo[k-1];
                assign w_big  = r_big[k-1];
            end

            assign w_trial = {w_rem, w_lo[QW-1]};
            assign w_diff  = w_trial - {1'b0, w_den};
            assign w_ge    = (w_trial >= {1'b0, w_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctrl[k] <= '0;
                end else if (i_en) begin
                    r_ctrl[k] <= w_ctrl;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_crd[k] <= w_crd;
                    r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_den[k] <= w_den;
                    r_lo[k]  <= {w_lo[QW-2:0], 1'b0};
                    r_quo[k] <= {w_quo[QW-2:0], w_ge};
                    r_big[k] <= w_big;
                end
            end
        end
    endgenerate

    assign o_ctrl    = r_ctrl[QW-1];
    assign o_start_x = r_crd[QW-1][W-1:0];
    assign o_start_y = r_crd[QW-1][2*W-1:W];
    assign o_dir_x   = r_crd[QW-1][3*W-1:2*W];
    assign o_dir_y   = r_crd[QW-1][4*W-1:3*W];
    assign o_quo     = r_quo[QW-1];
    assign o_big     = r_big[QW-1];

endmodule
`default_nettype wire

// ===== rtl/lsg_back.sv =====
// Back end: scalar saturation, point offset products, final sum and status.
`default_nettype none
module lsg_back #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire lsg_pkg::t_ctrl              i_ctrl,
    input  wire [COORD_WIDTH-1:0]            i_start_x,
    input  wire [COORD_WIDTH-1:0]            i_start_y,
    input  wire [COORD_WIDTH-1:0]            i_dir_x,
    input  wire [COORD_WIDTH-1:0]            i_dir_y,
    input  wire [COORD_WIDTH+FRAC_BITS+1:0]  i_quo,
    input  wire                              i_big,
    output logic                             o_valid,
    output logic [COORD_WIDTH-1:0]           o_result_x,
    output logic [COORD_WIDTH-1:0]           o_result_y,
    output logic [COORD_WIDTH-1:0]           o_scalar,
    output lsg_pkg::t_status                 o_status
);
    import lsg_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + F + 2;
    localparam logic [QW-1:0] QMAX_POS = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QW-1:0] QMAX_NEG = QMAX_POS + QW'(1);
    localparam logic [W-1:0]  SMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMIN     = {1'b1, {(W-1){1'b0}}};

    // B1: multiplier operand, scalar result
    logic [QW-1:0] n1_l;
    logic [W-1:0]  n1_ax, n1_ay, n1_sat_val, n1_sc;
    logic          n1_nx, n1_ny, n1_neg, n1_ovf, n1_sc_sat;
    t_ctrl         r1_ctrl;
    logic [QW-1:0] r1_l;
    logic [W-1:0]  r1_ax, r1_ay, r1_sx, r1_sy, r1_sc;
    logic          r1_nx, r1_ny, r1_sc_sat;

    always_comb begin
        n1_ax  = i_dir_x[W-1] ? W'(-i_dir_x) : i_dir_x;
        n1_ay  = i_dir_y[W-1] ? W'(-i_dir_y) : i_dir_y;
        // an oversized quotient is nonzero even when its low bits are all zero
        n1_neg = i_ctrl.q_neg && ((i_quo != '0) || i_big);
        n1_ovf = i_big || (n1_neg ? (i_quo > QMAX_NEG) : (i_quo > QMAX_POS));
        if (n1_ovf) begin
            n1_sat_val = n1_neg ? SMIN : SMAX;
        end else begin
            n1_sat_val = n1_neg ? W'(-i_quo[W-1:0]) : i_quo[W-1:0];
        end
        n1_l      = i_quo;
        n1_nx     = i_ctrl.q_neg ^ i_dir_x[W-1];
        n1_ny     = i_ctrl.q_neg ^ i_dir_y[W-1];
        n1_sc     = '0;
        n1_sc_sat = 1'b0;
        case (i_ctrl.func)
            FUNC_GRAD: begin
                n1_sc     = i_ctrl.degen ? SMAX : n1_sat_val;
                n1_sc_sat = !i_ctrl.degen && n1_ovf;
            end
            FUNC_CLOSEST: begin
                if (i_ctrl.t_zero) begin
                    n1_l = '0;
                end else if (i_ctrl.t_one) begin
                    n1_l = QW'(1) << F;
                end
                n1_nx = i_dir_x[W-1];
                n1_ny = i_dir_y[W-1];
                n1_sc = i_ctrl.degen ? '0 : n1_l[W-1:0];
            end
            FUNC_ISECT: begin
                // an oversized lambda saturates the point unless dir is zero
                if (i_big) begin
                    n1_l = '1;
                end
            end
            default: begin
                n1_sc     = i_ctrl.degen ? '0 : n1_sat_val;
                n1_sc_sat = !i_ctrl.degen && n1_ovf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl <= '0;
        end else if (i_en) begin
            r1_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_l      <= n1_l;
            r1_ax     <= n1_ax;
            r1_ay     <= n1_ay;
            r1_nx     <= n1_nx;
            r1_ny     <= n1_ny;
            r1_sx     <= i_start_x;
            r1_sy     <= i_start_y;
            r1_sc     <= n1_sc;
            r1_sc_sat <= n1_sc_sat;
        end
    end

    // B2: partial products, low and high halves of the multiplier operand
    t_ctrl           r2_ctrl;
    logic [2*W-1:0]  r2_plx, r2_ply;
    logic [QW-1:0]   r2_phx, r2_phy;
    logic [W-1:0]    r2_sx, r2_sy, r2_sc;
    logic            r2_nx, r2_ny, r2_sc_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctrl <= '0;
        end else if (i_en) begin
            r2_ctrl <= r1_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_plx    <= r1_l[W-1:0] * r1_ax;
            r2_ply    <= r1_l[W-1:0] * r1_ay;
            r2_phx    <= r1_l[QW-1:W] * r1_ax;
            r2_phy    <= r1_l[QW-1:W] * r1_ay;
            r2_sx     <= r1_sx;
            r2_sy     <= r1_sy;
            r2_nx     <= r1_nx;
            r2_ny     <= r1_ny;
            r2_sc     <= r1_sc;
            r2_sc_sat <= r1_sc_sat;
        end
    end

    // B3: combine, drop fraction, cap the magnitude
    logic [QW+W-1:0] n3_px, n3_py;
    logic [2*W+1:0]  n3_shx, n3_shy;
    t_ctrl           r3_ctrl;
    logic [W:0]      r3_mx, r3_my;
    logic [W-1:0]    r3_sx, r3_sy, r3_sc;
    logic            r3_nx, r3_ny, r3_sc_sat;

    assign n3_px  = {{(F+2){1'b0}}, r2_plx} + {r2_phx, {W{1'b0}}};
    assign n3_py  = {{(F+2){1'b0}}, r2_ply} + {r2_phy, {W{1'b0}}};
    assign n3_shx = n3_px[QW+W-1:F];
    assign n3_shy = n3_py[QW+W-1:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctrl <= '0;
        end else if (i_en) begin
            r3_ctrl <= r2_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mx     <= (n3_shx[2*W+1:W] != '0) ? {1'b1, {W{1'b0}}} : {1'b0, n3_shx[W-1:0]};
            r3_my     <= (n3_shy[2*W+1:W] != '0) ? {1'b1, {W{1'b0}}} : {1'b0, n3_shy[W-1:0]};
            r3_sx     <= r2_sx;
            r3_sy     <= r2_sy;
            r3_nx     <= r2_nx;
            r3_ny     <= r2_ny;
            r3_sc     <= r2_sc;
            r3_sc_sat <= r2_sc_sat;
        end
    end

    // B4: start + offset, saturate, output register
    logic [W+1:0] n4_sum_x, n4_sum_y;
    logic [W-1:0] n4_px, n4_py, n4_rx, n4_ry;
    logic         n4_satx, n4_saty, n4_pt;
    t_status      n4_status;
    logic         r4_valid;

    always_comb begin
        n4_sum_x = {{2{r3_sx[W-1]}}, r3_sx} +
                   (r3_nx ? (W+2)'(-{1'b0, r3_mx}) : {1'b0, r3_mx});
        n4_sum_y = {{2{r3_sy[W-1]}}, r3_sy} +
                   (r3_ny ? (W+2)'(-{1'b0, r3_my}) : {1'b0, r3_my});
        n4_satx  = (n4_sum_x[W+1:W-1] != 3'b000) && (n4_sum_x[W+1:W-1] != 3'b111);
        n4_saty  = (n4_sum_y[W+1:W-1] != 3'b000) && (n4_sum_y[W+1:W-1] != 3'b111);
        n4_px    = n4_satx ? (n4_sum_x[W+1] ? SMIN : SMAX) : n4_sum_x[W-1:0];
        n4_py    = n4_saty ? (n4_sum_y[W+1] ? SMIN : SMAX) : n4_sum_y[W-1:0];
        n4_pt    = 1'b0;
        n4_rx    = '0;
        n4_ry    = '0;
        case (r3_ctrl.func)
            FUNC_CLOSEST: begin
                n4_pt = !r3_ctrl.degen;
                n4_rx = r3_ctrl.degen ? r3_sx : n4_px;
                n4_ry = r3_ctrl.degen ? r3_sy : n4_py;
            end
            FUNC_ISECT: begin
                n4_pt = !r3_ctrl.degen;
                n4_rx = r3_ctrl.degen ? '0 : n4_px;
                n4_ry = r3_ctrl.degen ? '0 : n4_py;
            end
            default: begin
                n4_pt = 1'b0;
            end
        endcase
        if (r3_ctrl.degen) begin
            n4_status = ST_DEGEN;
        end else if (r3_sc_sat || (n4_pt && (n4_satx || n4_saty))) begin
            n4_status = ST_SAT;
        end else begin
            n4_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_result_x <= n4_rx;
            o_result_y <= n4_ry;
            o_scalar   <= r3_sc;
            o_status   <= n4_status;
        end
    end

    assign o_valid = r4_valid;

endmodule
`default_nettype wire
